// ----- rtl/tdq_pkg.sv -----
// ----------------------------------------------------------------------------
// tdq_pkg: shared types and codes for the timer deadline queue
// Opcodes, result kinds and the sequencer state type.
// ----------------------------------------------------------------------------
package tdq_pkg;

   localparam int TimeWidth = 48;
   localparam int IdWidth   = 32;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_HANDLE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_ADDED     = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_REMOVED   = 3'd2,
      KIND_NOT_FOUND = 3'd3,
      KIND_REMAINING = 3'd4,
      KIND_EMPTY     = 3'd5,
      KIND_FIRED     = 3'd6,
      KIND_NONE_DUE  = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_OUT
   } state_type;

   // deadline = now + period, saturated at all ones
   function automatic logic [TimeWidth-1:0] sat_add(
      input logic [TimeWidth-1:0] now_v,
      input logic [IdWidth-1:0]   per_v);
      logic [TimeWidth:0] sum_v;
      sum_v = {1'b0, now_v} + {{(TimeWidth+1-IdWidth){1'b0}}, per_v};
      sat_add = sum_v[TimeWidth] ? {TimeWidth{1'b1}} : sum_v[TimeWidth-1:0];
   endfunction

endpackage

// ----- rtl/tdq_compare.sv -----
// ----------------------------------------------------------------------------
// tdq_compare: shared ordering unit
// Decides whether a candidate slot orders before the current best one.
// ----------------------------------------------------------------------------
module tdq_compare (
   input  logic [tdq_pkg::TimeWidth-1:0] cand_deadline,
   input  logic [tdq_pkg::IdWidth-1:0]   cand_id,
   input  logic [tdq_pkg::TimeWidth-1:0] best_deadline,
   input  logic [tdq_pkg::IdWidth-1:0]   best_id,
   output logic                          earlier
);
   import tdq_pkg::*;
   // equal deadlines are ordered by the lower timer id
   always_comb begin
      if (cand_deadline != best_deadline) begin
         earlier = cand_deadline < best_deadline;
      end else begin
         earlier = cand_id < best_id;
      end
   end
endmodule

// ----- rtl/timer_deadline_queue.sv -----
// ----------------------------------------------------------------------------
// timer_deadline_queue: table of timers with add, remove, query and handle
// One slot is examined per cycle by a shared compare unit.
// ----------------------------------------------------------------------------
// Sequence: after a request is accepted, every slot is scanned in turn, then a
// decide state registers the result, which is shown in the output state until
// it is taken. A new request is not accepted until the last result is taken.
// Handle: one scan per fired timer; a handle with nothing due takes one scan.
// req_stall is high while in work. Synchronous active-high reset clears valid
// bits, id counter, sequencer and the result valid flag.
module timer_deadline_queue #(
   parameter int MAX_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [47:0] req_now_ms,
   input  logic [31:0] req_period_ms,
   input  logic        req_repeat_after_fire,
   input  logic [31:0] req_target_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [31:0] rsp_timer_id,
   output logic [47:0] rsp_remaining_ms,
   output logic        rsp_last
);
   import tdq_pkg::*;

   localparam int SW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

   // slot storage: valid bits in flops, payload without reset
   logic [MAX_TIMERS-1:0] valid_ff, valid_in;
   logic [MAX_TIMERS-1:0] fired_ff, fired_in;
   logic [IdWidth-1:0]    id_mem [MAX_TIMERS];
   logic [TimeWidth-1:0]  dl_mem [MAX_TIMERS];
   logic [IdWidth-1:0]    per_mem [MAX_TIMERS];
   logic                  rep_mem [MAX_TIMERS];

   logic [IdWidth-1:0] id_counter_ff, id_counter_in;
   state_type          state_ff, state_in;

   // latched request
   opcode_type           op_ff;
   logic [TimeWidth-1:0] now_ff;
   logic [IdWidth-1:0]   per_ff, tgt_ff;
   logic                 rep_ff;

   // scan state; more_ff marks a second due timer seen in a handle scan
   logic [SW:0]          idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic                 more_ff, more_in;
   logic [SW-1:0]        best_ff, best_in;
   logic [TimeWidth-1:0] bdl_ff, bdl_in;
   logic [IdWidth-1:0]   bid_ff, bid_in;

   // response register
   logic               rv_ff, rv_in;
   logic [2:0]         rk_ff, rk_in;
   logic [31:0]        rid_ff, rid_in;
   logic [47:0]        rrem_ff, rrem_in;
   logic               rlast_ff, rlast_in;

   // write port into slot storage
   logic                 wr_en;
   logic                 wr_new;
   logic [SW-1:0]        wr_slot;
   logic [TimeWidth-1:0] wr_dl;

   logic [SW-1:0]      cur;
   logic               earlier;
   logic               due_live;
   logic               cand;

   assign cur = idx_ff[SW-1:0];

   tdq_compare u_cmp (
      .cand_deadline(dl_mem[cur]),
      .cand_id      (id_mem[cur]),
      .best_deadline(bdl_ff),
      .best_id      (bid_ff),
      .earlier      (earlier)
   );

   // slot is held, not yet fired in this handle, and due
   assign due_live = valid_ff[cur] && !fired_ff[cur] && (dl_mem[cur] <= now_ff);

   // per-op candidate test for the slot under scan
   always_comb begin
      unique case (op_ff)
         OP_ADD:    cand = !valid_ff[cur] && !found_ff;
         OP_REMOVE: cand = valid_ff[cur] && !found_ff && (id_mem[cur] == tgt_ff);
         OP_QUERY:  cand = valid_ff[cur] && (!found_ff || earlier);
         default:   cand = due_live && (!found_ff || earlier);
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (idx_ff == (SW+1)'(MAX_TIMERS - 1)) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = rlast_ff ? ST_IDLE : ST_SCAN;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      valid_in      = valid_ff;
      fired_in      = fired_ff;
      id_counter_in = id_counter_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      more_in       = more_ff;
      best_in       = best_ff;
      bdl_in        = bdl_ff;
      bid_in        = bid_ff;
      rv_in         = rv_ff;
      rk_in         = rk_ff;
      rid_in        = rid_ff;
      rrem_in       = rrem_ff;
      rlast_in      = rlast_ff;
      wr_en         = 1'b0;
      wr_new        = 1'b0;
      wr_slot       = best_ff;
      wr_dl         = sat_add(now_ff, per_ff);
      unique case (state_ff)
         ST_IDLE: begin
            idx_in   = '0;
            found_in = 1'b0;
            more_in  = 1'b0;
            fired_in = '0;
         end
         ST_SCAN: begin
            if (cand) begin
               found_in = 1'b1;
               best_in  = cur;
               bdl_in   = dl_mem[cur];
               bid_in   = id_mem[cur];
            end
            if (op_ff == OP_HANDLE && due_live && found_ff) more_in = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_DECIDE: begin
            rv_in    = 1'b1;
            rlast_in = 1'b1;
            rid_in   = '0;
            rrem_in  = '0;
            unique case (op_ff)
               OP_ADD: begin
                  if (found_ff) begin
                     id_counter_in     = id_counter_ff + 1'b1;
                     valid_in[best_ff] = 1'b1;
                     wr_en             = 1'b1;
                     wr_new            = 1'b1;
                     rk_in             = KIND_ADDED;
                     rid_in            = id_counter_ff + 1'b1;
                  end else begin
                     rk_in = KIND_FULL;
                  end
               end
               OP_REMOVE: begin
                  rid_in = tgt_ff;
                  if (found_ff) begin
                     valid_in[best_ff] = 1'b0;
                     rk_in             = KIND_REMOVED;
                  end else begin
                     rk_in = KIND_NOT_FOUND;
                  end
               end
               OP_QUERY: begin
                  if (found_ff) begin
                     rk_in   = KIND_REMAINING;
                     rrem_in = (bdl_ff > now_ff) ? bdl_ff - now_ff : '0;
                  end else begin
                     rk_in = KIND_EMPTY;
                  end
               end
               default: begin
                  // firing one timer leaves the others as they were, so this
                  // is the last firing unless a second due timer was seen
                  if (found_ff) begin
                     rk_in             = KIND_FIRED;
                     rid_in            = bid_ff;
                     rlast_in          = !more_ff;
                     fired_in[best_ff] = 1'b1;
                     if (rep_mem[best_ff]) begin
                        wr_en = 1'b1;
                        wr_dl = sat_add(now_ff, per_mem[best_ff]);
                     end else begin
                        valid_in[best_ff] = 1'b0;
                     end
                  end else begin
                     rk_in = KIND_NONE_DUE;
                  end
               end
            endcase
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rv_in    = 1'b0;
               idx_in   = '0;
               found_in = 1'b0;
               more_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         id_counter_ff <= '0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         id_counter_ff <= id_counter_in;
         rv_ff         <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      fired_ff <= fired_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      more_ff  <= more_in;
      best_ff  <= best_in;
      bdl_ff   <= bdl_in;
      bid_ff   <= bid_in;
      rk_ff    <= rk_in;
      rid_ff   <= rid_in;
      rrem_ff  <= rrem_in;
      rlast_ff <= rlast_in;
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff  <= opcode_type'(req_opcode);
         now_ff <= req_now_ms;
         per_ff <= req_period_ms;
         tgt_ff <= req_target_id;
         rep_ff <= req_repeat_after_fire;
      end
      if (wr_en) begin
         dl_mem[wr_slot] <= wr_dl;
         if (wr_new) begin
            id_mem[wr_slot]  <= id_counter_in;
            per_mem[wr_slot] <= per_ff;
            rep_mem[wr_slot] <= rep_ff;
         end
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_result_kind  = rk_ff;
   assign rsp_timer_id     = rid_ff;
   assign rsp_remaining_ms = rrem_ff;
   assign rsp_last         = rlast_ff;

   // assertions
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !req_stall)
      else $error("stall raised while idle");
   a_id_step: assert property (@(posedge clock) disable iff (reset)
      (id_counter_ff != $past(id_counter_ff)) |->
      (id_counter_ff == $past(id_counter_ff) + 1'b1))
      else $error("id counter jumped");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_kind)
      && $stable(rsp_timer_id) && $stable(rsp_remaining_ms) && $stable(rsp_last)))
      else $error("stalled result changed");
   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid)
      else $error("result shown during scan");
endmodule
